// File: hdl/bpa_pkg.sv
// bpa_pkg: shared types and constants for the bitmap page allocator.
// No dependencies.
package bpa_pkg;

  localparam int IDX_W    = 16;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

endpackage

// File: hdl/bpa_map_ram.sv
// bpa_map_ram: used-page bitmap storage, one write port, one registered read port.
// No dependencies.
module bpa_map_ram #(
  parameter int DEPTH  = 2048,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/bpa_div.sv
// bpa_div: splits a page index into bitmap word and bit by shift and mask, registered.
// WORD_BITS must be a power of two. Depends on bpa_pkg.
module bpa_div #(
  parameter int WORD_BITS = 32,
  parameter int BW        = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bpa_pkg::IDX_W-1:0] dividend,
  output logic                      done,
  output logic [bpa_pkg::IDX_W-1:0] quotient,
  output logic [BW-1:0]             remainder
);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend >> BW;
      remainder <= dividend[BW-1:0];
    end
  end

  a_done_after_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start))
    else $error("split done without a start");

  a_split_exact: assert property (@(posedge clk) disable iff (rst)
    done |-> (int'(quotient) * WORD_BITS + int'(remainder)) == int'($past(dividend)))
    else $error("word and bit do not rebuild the page index");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    done |-> !start)
    else $error("split restarted while its result is in use");

endmodule

// File: hdl/bitmap_page_allocator_core.sv
// bitmap_page_allocator_core: next-fit free-page allocator over a used-page bitmap.
// Depends on bpa_pkg, bpa_map_ram, bpa_div.
//
// A request is taken when start is high and busy is low; its result shows on status and
// granted_index for exactly one cycle with done high, and the receiver cannot stall it.
// After reset the block sweeps the bitmap memory once to load its reset contents, one
// word per cycle with busy high. An allocate reads one bitmap word per cycle from the
// hint word upward through the memory read port, scanning at most NUM_WORDS - hint
// words. A free splits the page index into word and bit with a shift and a mask, then
// does a read-modify-write of one word (states S_DIV, S_FRD, S_FWR); an
// out-of-range free answers the next cycle. busy is low in the cycle done is shown.
// WORD_BITS must be a power of two.
module bitmap_page_allocator_core #(
  parameter int TOTAL_PAGES    = 65536,
  parameter int RESERVED_PAGES = 2,
  parameter int WORD_BITS      = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         func,
  input  logic [bpa_pkg::IDX_W-1:0]    page_index,
  output logic                         done,
  output logic [bpa_pkg::STATUS_W-1:0] status,
  output logic [bpa_pkg::IDX_W-1:0]    granted_index
);
  import bpa_pkg::*;

  localparam int NUM_WORDS = (TOTAL_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int PW        = $clog2(NUM_WORDS * WORD_BITS + 1);
  localparam logic [AW-1:0] LAST = AW'(NUM_WORDS - 1);

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_SCAN = 6'b000100,
    S_DIV  = 6'b001000,
    S_FRD  = 6'b010000,
    S_FWR  = 6'b100000
  } state_t;

  state_t               state;
  logic [AW-1:0]        hint_word;
  logic [PW-1:0]        hint_base;
  logic [AW-1:0]        rd_ptr;
  logic [PW-1:0]        rd_base;
  logic [AW-1:0]        chk_ptr;
  logic [PW-1:0]        chk_base;
  logic                 chk_valid;
  logic [BW-1:0]        bit_sel;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] clear_bits;
  logic                 found;
  logic [BW-1:0]        low_idx;
  logic [WORD_BITS-1:0] low_mask;
  logic [WORD_BITS-1:0] free_mask;
  logic [WORD_BITS-1:0] reset_word;

  logic                 accept;
  logic                 out_of_range;
  logic                 div_start;
  logic                 div_done;
  logic [IDX_W-1:0]     div_quot;
  logic [BW-1:0]        div_rem;

  function automatic logic [BW-1:0] lowest_one(input logic [WORD_BITS-1:0] v);
    logic [BW-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = BW'(i);
    end
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] init_word(input logic [PW-1:0] base);
    logic [WORD_BITS-1:0] w;
    int p;
    for (int b = 0; b < WORD_BITS; b++) begin
      p    = int'(base) + b;
      w[b] = (p < RESERVED_PAGES) || (p >= TOTAL_PAGES);
    end
    return w;
  endfunction

  assign busy         = (state != S_IDLE);
  assign accept       = start && !busy;
  assign out_of_range = int'(page_index) >= TOTAL_PAGES;
  assign div_start    = accept && (func == FUNC_FREE) && !out_of_range;

  assign clear_bits = ~rd_data;
  assign found      = |clear_bits;
  assign low_idx    = lowest_one(clear_bits);
  assign low_mask   = {{(WORD_BITS-1){1'b0}}, 1'b1} << low_idx;
  assign free_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_sel;
  assign reset_word = init_word(rd_base);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_ptr;
    wr_data = reset_word;
    priority if (state == S_CLR) begin
      wr_en = 1'b1;
    end else if (state == S_SCAN && chk_valid && found) begin
      wr_en   = 1'b1;
      wr_addr = chk_ptr;
      wr_data = rd_data | low_mask;
    end else if (state == S_FWR) begin
      wr_en   = 1'b1;
      wr_data = rd_data & ~free_mask;
    end
  end

  bpa_map_ram #(
    .DEPTH  (NUM_WORDS),
    .WIDTH  (WORD_BITS),
    .ADDR_W (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_ptr),
    .rd_data (rd_data)
  );

  bpa_div #(
    .WORD_BITS (WORD_BITS),
    .BW        (BW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (page_index),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      rd_ptr    <= '0;
      rd_base   <= '0;
      hint_word <= '0;
      hint_base <= '0;
      chk_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLR: begin
          if (rd_ptr == LAST) begin
            state <= S_IDLE;
          end else begin
            rd_ptr  <= rd_ptr + 1'b1;
            rd_base <= rd_base + PW'(WORD_BITS);
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (func == FUNC_ALLOC) begin
              rd_ptr    <= hint_word;
              rd_base   <= hint_base;
              chk_valid <= 1'b0;
              state     <= S_SCAN;
            end else if (out_of_range) begin
              done <= 1'b1;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_SCAN: begin
          chk_valid <= 1'b1;
          chk_ptr   <= rd_ptr;
          chk_base  <= rd_base;
          if (rd_ptr != LAST) begin
            rd_ptr  <= rd_ptr + 1'b1;
            rd_base <= rd_base + PW'(WORD_BITS);
          end
          if (chk_valid && found) begin
            hint_word <= chk_ptr;
            hint_base <= chk_base;
            done      <= 1'b1;
            state     <= S_IDLE;
          end else if (chk_valid && chk_ptr == LAST) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            rd_ptr  <= AW'(div_quot);
            bit_sel <= div_rem;
            state   <= S_FRD;
          end
        end
        S_FRD: begin
          state <= S_FWR;
        end
        S_FWR: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && func == FUNC_FREE && out_of_range) begin
      status        <= ST_RANGE;
      granted_index <= '0;
    end else if (state == S_SCAN && chk_valid && found) begin
      status        <= ST_OK;
      granted_index <= IDX_W'(chk_base + PW'(low_idx));
    end else if (state == S_SCAN && chk_valid) begin
      status        <= ST_FULL;
      granted_index <= '0;
    end else if (state == S_FWR) begin
      status        <= ST_OK;
      granted_index <= '0;
    end
  end

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) != S_IDLE) || $past(accept && out_of_range))
    else $error("result without a request in progress");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> granted_index == '0)
    else $error("nonzero index on failed request");

  a_hint_monotonic: assert property (@(posedge clk) disable iff (rst)
    $past(state) != S_CLR |-> hint_word >= $past(hint_word))
    else $error("hint moved backward");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept && !(func == FUNC_FREE && out_of_range) |=> busy && !done)
    else $error("request not held busy");

endmodule
